// ----- rtl/ftws_pkg.sv -----
// ----------------------------------------------------------------------------
// ftws_pkg: shared types and constants for the frame time window statistics
// Widths of samples and counters, register indexes and the controller states.
// ----------------------------------------------------------------------------
package ftws_pkg;

	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned CFG_W    = 24;
	localparam int unsigned RANK_W   = 7;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE_RANK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_US       = 1'd1;

	localparam logic [RANK_W-1:0]   RANK_RESET   = 7'd99;
	localparam logic [SAMPLE_W-1:0] BUDGET_RESET = 24'd33333;

	// floor(x / 100) as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 199799
	localparam int unsigned PCT_RECIP = 167773;
	localparam int unsigned PCT_SHIFT = 24;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t frame_time_us;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		logic [COUNT_W-1:0] over_budget_count;
		sample_t            last_us;
		sample_t            peak_us;
		sample_t            mean_us;
		sample_t            percentile_us;
	} out_item_t;

	// Command broadcast to every sort cell in the same cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_REMOVE,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		sample_t  value;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_SCAN,
		ST_DIVIDE,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/ftws_if.sv -----
// ----------------------------------------------------------------------------
// ftws_stream_if: valid/ready channel
// Carries one item of the given payload type.
// ----------------------------------------------------------------------------
interface ftws_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ftws_sort_cell.sv -----
// ----------------------------------------------------------------------------
// ftws_sort_cell: one slot of the sorted window
// Holds one sample and shifts to or from its neighbor on remove and insert.
// ----------------------------------------------------------------------------
module ftws_sort_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ftws_pkg::cell_cmd_t cmd,
	input  logic                left_valid,
	input  ftws_pkg::sample_t   left_value,
	input  logic                right_valid,
	input  ftws_pkg::sample_t   right_value,
	output logic                valid,
	output ftws_pkg::sample_t   value
);
	import ftws_pkg::*;

	logic    valid_q;
	sample_t value_q;
	logic    kill;
	logic    gt_self;
	logic    gt_left;

	// chain is sorted: cells from the first entry equal to the removed value on
	// are the ones at or above it, so each cell decides locally
	assign kill    = valid_q && value_q >= cmd.value;
	// new value goes after equal entries
	assign gt_self = valid_q && value_q > cmd.value;
	assign gt_left = left_valid && left_value > cmd.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_REMOVE: if (kill) valid_q <= right_valid;
				CELL_INSERT: if (!valid_q && left_valid) valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_REMOVE: if (kill) value_q <= right_value;
			CELL_INSERT: begin
				if (gt_left) value_q <= left_value;
				else if (gt_self || !valid_q) value_q <= cmd.value;
			end
			default: ;
		endcase
	end

	assign valid = valid_q;
	assign value = value_q;
endmodule

// ----- rtl/ftws_divider.sv -----
// ----------------------------------------------------------------------------
// ftws_divider: restoring divider, one quotient bit per cycle
// Divides the window sum by the held count.
// ----------------------------------------------------------------------------
module ftws_divider #(
	parameter int unsigned NUM_W = 34,
	parameter int unsigned DEN_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;

	assign trial = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= numer;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, denom}) begin
				rem_q  <= trial - {1'b0, denom};
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && cnt_q == CNT_W'(1);
	assign quot = quot_q;
endmodule

// ----- rtl/frame_time_window_stats_unit.sv -----
// ----------------------------------------------------------------------------
// frame_time_window_stats_unit: sliding-window frame time statistics
// Ring, sorted cell chain, counters, mean and percentile for each item.
// ----------------------------------------------------------------------------
// One item at a time. Each accepted item goes through a ring read in the
// accept cycle, one remove and one insert step on the chain of sort cells, a
// setup step, the serial restoring divider for the mean (one bit per cycle
// over the sum width), and an output step; the percentile entry is picked
// during the divide by a registered mux over the cell chain. The next item
// is taken while a result waits on the output; a stalled output holds the
// block in its output step. Reset is immediate: no clearing pass.
module frame_time_window_stats_unit #(
	parameter int unsigned WINDOW = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ftws_stream_if.sink               in_ch,
	ftws_stream_if.source             out_ch,
	input  logic                      cfg_we,
	input  logic [ftws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ftws_pkg::CFG_W-1:0]     cfg_data
);
	import ftws_pkg::*;

	localparam int unsigned SLOT_W = $clog2(WINDOW);
	localparam int unsigned HELD_W = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W  = SAMPLE_W + HELD_W;
	localparam int unsigned PROD_W = HELD_W + RANK_W;
	localparam int unsigned RPROD_W = PROD_W + PCT_SHIFT;
	localparam int unsigned CELL_IDX_W = $clog2(WINDOW + 2);

	state_t state_q, state_d;

	logic [RANK_W-1:0] rank_q;
	sample_t           budget_q;

	sample_t           ring_mem [WINDOW];
	sample_t           old_q;
	sample_t           t_q;
	logic [SLOT_W-1:0] slot_q;
	logic [HELD_W-1:0] held_q;
	logic [SUM_W-1:0]  sum_q;
	sample_t           worst_q;
	logic [COUNT_W-1:0] seen_q, over_q;
	logic              full_q;

	cell_cmd_t cmd;
	logic      cv [WINDOW+2];
	sample_t   cval [WINDOW+2];

	logic [PROD_W-1:0] prod_q, idx_q;
	logic [RPROD_W-1:0] prod_recip;
	logic [PROD_W-1:0] quo_100;
	logic [PROD_W-1:0] idx_cap;
	sample_t           pct_q;
	logic              div_start, div_done;
	logic [SUM_W-1:0]  div_quot;
	out_item_t         out_q;
	logic              out_valid_q;
	logic              out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= RANK_RESET;
			budget_q <= BUDGET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERCENTILE_RANK: rank_q <= cfg_data[RANK_W-1:0];
				REG_BUDGET_US:       budget_q <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = state_q == ST_IDLE;
	assign div_start   = state_q == ST_SCAN;
	assign out_load    = state_q == ST_OUT && (!out_valid_q || out_ch.ready);

	always_comb begin
		state_d = state_q;
		cmd.op    = CELL_HOLD;
		cmd.value = t_q;
		case (state_q)
			ST_IDLE:   if (in_ch.valid && in_ch.ready) state_d = ST_REMOVE;
			ST_REMOVE: begin
				cmd.value = old_q;
				if (full_q) cmd.op = CELL_REMOVE;
				state_d = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.op  = CELL_INSERT;
				state_d = ST_SCAN;
			end
			ST_SCAN:   state_d = ST_DIVIDE;
			ST_DIVIDE: if (div_done) state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			t_q   <= in_ch.payload.frame_time_us;
			old_q <= ring_mem[slot_q];
		end
		if (state_q == ST_REMOVE) ring_mem[slot_q] <= t_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			held_q  <= '0;
			sum_q   <= '0;
			worst_q <= '0;
			seen_q  <= '0;
			over_q  <= '0;
			full_q  <= 1'b0;
		end else if (state_q == ST_REMOVE) begin
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
			sum_q  <= sum_q - (full_q ? SUM_W'(old_q) : '0) + SUM_W'(t_q);
			if (!full_q) held_q <= held_q + HELD_W'(1);
			if (held_q == HELD_W'(WINDOW - 1)) full_q <= 1'b1;
			if (t_q > worst_q) worst_q <= t_q;
			if (seen_q != '1) seen_q <= seen_q + COUNT_W'(1);
			if (t_q > budget_q && over_q != '1) over_q <= over_q + COUNT_W'(1);
		end
	end

	// left end reads as occupied so the first free cell takes an insert
	assign cv[0] = 1'b1;
	assign cval[0] = '0;
	assign cv[WINDOW+1] = 1'b0;
	assign cval[WINDOW+1] = '0;

	for (genvar g = 0; g < WINDOW; g++) begin : g_cell
		logic    v_o;
		sample_t d_o;
		ftws_sort_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.left_valid(cv[g]), .left_value(cval[g]),
			.right_valid(cv[g+2]), .right_value(cval[g+2]),
			.valid(v_o), .value(d_o)
		);
		assign cv[g+1]   = v_o;
		assign cval[g+1] = d_o;
	end

	// percentile index: product in SCAN, then pick cell during DIVIDE
	assign prod_recip = RPROD_W'(prod_q) * RPROD_W'(PCT_RECIP);
	assign quo_100    = prod_recip[PCT_SHIFT +: PROD_W];
	assign idx_cap = (quo_100 >= PROD_W'(held_q)) ? PROD_W'(held_q) - PROD_W'(1) : quo_100;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(held_q) * PROD_W'(rank_q);
		idx_q  <= idx_cap;
		pct_q  <= cval[CELL_IDX_W'(idx_q) + CELL_IDX_W'(1)];
	end

	ftws_divider #(.NUM_W(SUM_W), .DEN_W(HELD_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.numer(sum_q), .denom(held_q), .done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.frame_count       <= seen_q;
			out_q.over_budget_count <= over_q;
			out_q.last_us           <= t_q;
			out_q.peak_us           <= worst_q;
			out_q.mean_us           <= div_quot[SAMPLE_W-1:0];
			out_q.percentile_us     <= pct_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
		else $error("pending result dropped or changed");
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(WINDOW)) else $error("held count overflow");
	a_full_match: assert property (@(posedge clk) disable iff (!arst_n)
		full_q == (held_q == HELD_W'(WINDOW))) else $error("full flag mismatch");
endmodule

// ----- sim/ftws_tb_if.sv -----
// ----------------------------------------------------------------------------
// ftws_tb_if: testbench side of the frame time statistics channels
// The block's own stream interface is used for both channels; this file only
// defines the expected-result type the bench checks against.
// ----------------------------------------------------------------------------
package ftws_tb_pkg;

	import ftws_pkg::*;

	// Expected result of one frame time item, same layout as the block's output.
	typedef out_item_t stats_t;

endpackage

// ----- sim/frame_time_window_stats_unit_tb.sv -----
// ----------------------------------------------------------------------------
// frame_time_window_stats_unit_tb: self-checking bench for the window stats
// Drives frame times with random gaps and output stalls, predicts counters,
// mean and percentile over a sliding window, and compares every result.
// ----------------------------------------------------------------------------
module frame_time_window_stats_unit_tb;

	import ftws_pkg::*;
	import ftws_tb_pkg::*;

	localparam int WIN = 256;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ftws_stream_if #(.payload_t(in_item_t))  in_ch();
	ftws_stream_if #(.payload_t(out_item_t)) out_ch();

	frame_time_window_stats_unit #(.WINDOW(WIN)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	sample_t ring_q[$];
	sample_t sorted_q[$];
	longint unsigned win_sum;
	sample_t worst_seen;
	logic [31:0] frames_seen, frames_over;
	logic [RANK_W-1:0] rank;
	sample_t budget;

	stats_t expected_stats[$];
	int mismatches;
	int idle_cycles;
	bit rx_hold;
	bit no_idle;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void predict_frame(input sample_t t);
		stats_t s;
		int pos;
		int idx;
		sample_t old;
		if (ring_q.size() >= WIN) begin
			old = ring_q.pop_front();
			win_sum -= old;
			for (int i = 0; i < sorted_q.size(); i++) begin
				if (sorted_q[i] == old) begin
					sorted_q.delete(i);
					break;
				end
			end
		end
		ring_q.push_back(t);
		win_sum += t;
		pos = 0;
		while (pos < sorted_q.size() && sorted_q[pos] <= t) pos++;
		sorted_q.insert(pos, t);
		if (frames_seen != 32'hFFFF_FFFF) frames_seen++;
		if (t > budget && frames_over != 32'hFFFF_FFFF) frames_over++;
		if (t > worst_seen) worst_seen = t;
		idx = (sorted_q.size() * rank) / 100;
		if (idx >= sorted_q.size()) idx = sorted_q.size() - 1;
		s.frame_count = frames_seen;
		s.over_budget_count = frames_over;
		s.last_us = t;
		s.peak_us = worst_seen;
		s.mean_us = sample_t'(win_sum / longint'(sorted_q.size()));
		s.percentile_us = sorted_q[idx];
		expected_stats.push_back(s);
	endfunction

	// valid stays high on return so back-to-back items need no gap; drain drops it
	task automatic send_frame(input sample_t t);
		while (!no_idle && $urandom_range(99) < 24) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload.frame_time_us <= t;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_frame(t);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PERCENTILE_RANK) rank = val[RANK_W-1:0];
		else budget = val;
		@(posedge clk);
	endtask

	// result checker and output stall control
	always @(posedge clk) begin
		stats_t w;
		stats_t g;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			g = out_ch.payload;
			if (expected_stats.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				mismatches++;
			end else begin
				w = expected_stats.pop_front();
				if (g.frame_count != w.frame_count)
					report("frame_count", g.frame_count, w.frame_count);
				if (g.over_budget_count != w.over_budget_count)
					report("over_budget_count", g.over_budget_count, w.over_budget_count);
				if (g.last_us != w.last_us) report("last_us", g.last_us, w.last_us);
				if (g.peak_us != w.peak_us) report("peak_us", g.peak_us, w.peak_us);
				if (g.mean_us != w.mean_us) report("mean_us", g.mean_us, w.mean_us);
				if (g.percentile_us != w.percentile_us)
					report("percentile_us", g.percentile_us, w.percentile_us);
			end
		end
		out_ch.ready <= !rx_hold && (no_idle || $urandom_range(99) >= 24);
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic test_extremes();
		send_frame(24'd0);
		send_frame(24'hFFFFFF);
		send_frame(24'd1);
		send_frame(24'd33333);
		send_frame(24'd33334);
		send_frame(24'h800000);
		send_frame(24'h7FFFFF);
		send_frame(24'h555555);
		send_frame(24'hAAAAAA);
		drain();
	endtask

	task automatic test_rank_and_budget();
		write_reg(REG_PERCENTILE_RANK, 24'd0);
		write_reg(REG_BUDGET_US, 24'd0);
		send_frame(24'd5);
		send_frame(24'd5);
		send_frame(24'd2);
		drain();
		write_reg(REG_PERCENTILE_RANK, 24'd100);
		write_reg(REG_BUDGET_US, 24'hFFFFFF);
		send_frame(24'd9);
		send_frame(24'hFFFFFF);
		drain();
		// rank above 100 clamps to the largest held sample
		write_reg(REG_PERCENTILE_RANK, 24'd127);
		send_frame(24'd3);
		drain();
		write_reg(REG_PERCENTILE_RANK, 24'd50);
		write_reg(REG_BUDGET_US, 24'd1000);
		send_frame(24'd1000);
		send_frame(24'd1001);
		drain();
	endtask

	// window wraps with many equal values so eviction must pick duplicates
	task automatic test_random(input int n, input int spread);
		sample_t t;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: t = sample_t'($urandom_range(spread));
				1: t = sample_t'(24'd33000 + $urandom_range(700));
				2: t = sample_t'($urandom);
				default: t = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
			endcase
			send_frame(t);
		end
		drain();
	endtask

	task automatic test_back_pressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
			end
			for (int i = 0; i < 20; i++) send_frame(sample_t'($urandom_range(50000)));
		join
		drain();
	endtask

	task automatic test_full_rate();
		no_idle = 1'b1;
		for (int i = 0; i < 150; i++) send_frame(sample_t'($urandom_range(40000)));
		drain();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		rx_hold = 1'b0;
		no_idle = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		win_sum = 0;
		worst_seen = '0;
		frames_seen = '0;
		frames_over = '0;
		rank = RANK_RESET;
		budget = BUDGET_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_rank_and_budget();
		write_reg(REG_PERCENTILE_RANK, 24'd99);
		write_reg(REG_BUDGET_US, 24'd33333);
		test_random(400, 15);
		test_back_pressure();
		write_reg(REG_PERCENTILE_RANK, CFG_W'($urandom_range(100)));
		write_reg(REG_BUDGET_US, CFG_W'($urandom));
		test_full_rate();
		write_reg(REG_PERCENTILE_RANK, 24'd1);
		test_random(400, 3);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
